### rtl/dwarf_encoded_value_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// Each expects signals clk and rst_n in the enclosing module.
`ifndef DWARF_ENCODED_VALUE_DECODER_MACROS_SVH
`define DWARF_ENCODED_VALUE_DECODER_MACROS_SVH

// same-cycle implication
`define DWEV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed");

// next-cycle implication
`define DWEV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

### rtl/dwev_pkg.sv
`default_nettype none

package dwev_pkg;

  // sizes
  localparam int unsigned POINTER_BYTES = 8;
  localparam int unsigned MAX_LEB_BYTES = 10;

  // encoding byte fields
  localparam logic [7:0] ENC_OMIT      = 8'hFF;
  localparam logic [7:0] ENC_APP_MASK  = 8'h70;
  localparam logic [7:0] ENC_APP_ABS   = 8'h00;
  localparam logic [7:0] ENC_APP_PCREL = 8'h10;
  localparam logic [3:0] FMT_ABSPTR    = 4'h0;
  localparam logic [3:0] FMT_ULEB      = 4'h1;
  localparam logic [3:0] FMT_UDATA2    = 4'h2;
  localparam logic [3:0] FMT_UDATA4    = 4'h3;
  localparam logic [3:0] FMT_UDATA8    = 4'h4;
  localparam logic [3:0] FMT_SLEB      = 4'h9;
  localparam logic [3:0] FMT_SDATA2    = 4'hA;
  localparam logic [3:0] FMT_SDATA4    = 4'hB;
  localparam logic [3:0] FMT_SDATA8    = 4'hC;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_UNSUPPORTED = 2'd1,
    ERR_LEB_LONG    = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  encoding;
    logic [63:0] byte_address;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    err_t        error_code;
    logic        needs_indirect;
  } out_item_t;

  // byte count of a fixed-size format, 0 for anything else
  function automatic logic [3:0] fixed_size(input logic [3:0] fmt);
    logic [3:0] sz;
    unique case (fmt)
      FMT_ABSPTR:             sz = 4'(POINTER_BYTES);
      FMT_UDATA2, FMT_SDATA2: sz = 4'd2;
      FMT_UDATA4, FMT_SDATA4: sz = 4'd4;
      FMT_UDATA8, FMT_SDATA8: sz = 4'd8;
      default:                sz = 4'd0;
    endcase
    return sz;
  endfunction

  function automatic logic encoding_supported(input logic [7:0] enc);
    logic fmt_ok;
    logic app_ok;
    fmt_ok = (enc[3:0] == FMT_ULEB) || (enc[3:0] == FMT_SLEB) ||
             (fixed_size(enc[3:0]) != 4'd0);
    app_ok = ((enc & ENC_APP_MASK) == ENC_APP_ABS) ||
             ((enc & ENC_APP_MASK) == ENC_APP_PCREL);
    return fmt_ok && app_ok;
  endfunction

endpackage

`default_nettype wire

### rtl/dwev_in_if.sv
`default_nettype none

interface dwev_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  encoding;
  logic [63:0] byte_address;

  modport source (output valid, data_byte, encoding, byte_address, input ready);
  modport sink   (input valid, data_byte, encoding, byte_address, output ready);
endinterface

`default_nettype wire

### rtl/dwev_out_if.sv
`default_nettype none

interface dwev_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [1:0]  error_code;
  logic        needs_indirect;

  modport source (output valid, value, error_code, needs_indirect, input ready);
  modport sink   (input valid, value, error_code, needs_indirect, output ready);
endinterface

`default_nettype wire

### rtl/dwarf_encoded_value_decoder.sv
`default_nettype none

// Channel   Dir  Payload                                   Handshake
// in_ch     in   data_byte[8] encoding[8] byte_address[64] valid/ready
// out_ch    out  value[64] error_code[2] needs_indirect[1] valid/ready
//
// One byte per cycle sustained while out_ch accepts results; a result appears once the request
// carrying a value's last byte has passed the input register, then the result register.
// The decode path between them is one shift/merge, sign extension and a 64-bit pc-relative add.
// Reset is synchronous, active low; it clears both stages and the decode state.
// A stalled result holds its register while the input register still takes
// one more request; both stages then hold until out_ch.ready.
module dwarf_encoded_value_decoder (
  input  wire logic clk,
  input  wire logic rst_n,
  dwev_in_if.sink   in_ch,
  dwev_out_if.source out_ch
);

  `include "dwarf_encoded_value_decoder_macros.svh"

  logic                s1_valid_r, s1_valid_nxt;
  dwev_pkg::in_item_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  dwev_pkg::out_item_t out_item_r;
  logic                adv;
  logic                in_take;
  logic                step_emit;
  dwev_pkg::out_item_t step_result;

  // stage control
  always_comb begin
    adv           = s1_valid_r && (!out_valid_r || out_ch.ready);
    in_take       = in_ch.valid && in_ch.ready;
    s1_valid_nxt  = in_take || (s1_valid_r && !adv);
    out_valid_nxt = adv ? step_emit : (out_valid_r && !out_ch.ready);
  end

  assign in_ch.ready = !s1_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{data_byte: in_ch.data_byte, encoding: in_ch.encoding,
                     byte_address: in_ch.byte_address};
    end
  end

  dwev_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .item   (s1_item_r),
    .emit   (step_emit),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && step_emit) begin
      out_item_r <= step_result;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.value          = out_item_r.value;
  assign out_ch.error_code     = out_item_r.error_code;
  assign out_ch.needs_indirect = out_item_r.needs_indirect;

  `DWEV_ASSERT_NOW(a_err_zero, out_valid_r && out_item_r.error_code != dwev_pkg::ERR_OK,
                   out_item_r.value == 64'd0 && !out_item_r.needs_indirect)
  `DWEV_ASSERT_NOW(a_ind_nonzero, out_valid_r && out_item_r.needs_indirect,
                   out_item_r.value != 64'd0)
  `DWEV_ASSERT_NEXT(a_silent_byte, adv && !step_emit, !out_valid_r)

endmodule

`default_nettype wire

### rtl/dwev_step.sv
`default_nettype none

// Per-byte decode step: holds the partial value and computes the result
// of one byte in a single combinational pass.
module dwev_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire dwev_pkg::in_item_t item,
  output logic                    emit,
  output dwev_pkg::out_item_t     result
);

  `include "dwarf_encoded_value_decoder_macros.svh"

  logic [63:0] acc_r,    acc_nxt;
  logic [3:0]  count_r,  count_nxt;
  logic        active_r, active_nxt;
  logic [7:0]  held_r,   held_nxt;

  logic        first;
  logic [7:0]  enc_c;
  logic [3:0]  fmt;
  logic [63:0] acc_base;
  logic [3:0]  cnt;
  logic [4:0]  cnt_inc;
  logic [6:0]  leb_shift;
  logic [7:0]  sleb_shift;
  logic [63:0] leb_acc;
  logic [63:0] fix_acc;
  logic [3:0]  size;
  logic [63:0] final_acc;
  logic [63:0] final_val;
  logic        is_leb;
  logic        done;

  // operand selection: a first byte starts from a clean accumulator
  always_comb begin
    first     = !active_r;
    enc_c     = first ? item.encoding : held_r;
    fmt       = enc_c[3:0];
    acc_base  = first ? 64'd0 : acc_r;
    cnt       = first ? 4'd0 : count_r;
    cnt_inc   = 5'(cnt) + 5'd1;
    is_leb    = (fmt == dwev_pkg::FMT_ULEB) || (fmt == dwev_pkg::FMT_SLEB);
    leb_shift = 7'(cnt) * 7'd7;
    sleb_shift = 8'(leb_shift) + 8'd7;
    size      = dwev_pkg::fixed_size(fmt);
  end

  // byte merge for both families
  always_comb begin
    leb_acc = acc_base;
    if (leb_shift < 7'd64) begin
      leb_acc = acc_base | (64'(item.data_byte[6:0]) << leb_shift[5:0]);
    end
    fix_acc = acc_base;
    if (cnt < 4'd8) begin
      fix_acc = acc_base | (64'(item.data_byte) << {cnt[2:0], 3'b000});
    end
  end

  // finish: sign extension, then pc-relative adjust
  always_comb begin
    final_acc = is_leb ? leb_acc : fix_acc;
    if (is_leb) begin
      if (fmt == dwev_pkg::FMT_SLEB && sleb_shift < 8'd64 && item.data_byte[6]) begin
        final_acc = leb_acc | ({64{1'b1}} << sleb_shift[5:0]);
      end
    end else if (fmt >= dwev_pkg::FMT_SDATA2) begin
      priority if (size == 4'd2 && fix_acc[15]) begin
        final_acc = fix_acc | {{48{1'b1}}, 16'd0};
      end else if (size == 4'd4 && fix_acc[31]) begin
        final_acc = fix_acc | {{32{1'b1}}, 32'd0};
      end else begin
        final_acc = fix_acc;
      end
    end
    final_val = final_acc;
    if ((enc_c & dwev_pkg::ENC_APP_MASK) == dwev_pkg::ENC_APP_PCREL &&
        final_acc != 64'd0) begin
      final_val = final_acc + item.byte_address + 64'd1;
    end
  end

  // step outcome and next state
  always_comb begin
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    active_nxt = active_r;
    held_nxt   = held_r;
    emit       = 1'b0;
    done       = 1'b0;
    result     = '{value: 64'd0, error_code: dwev_pkg::ERR_OK, needs_indirect: 1'b0};
    if (en) begin
      priority if (first && item.encoding == dwev_pkg::ENC_OMIT) begin
        emit = 1'b1;
      end else if (first && !dwev_pkg::encoding_supported(item.encoding)) begin
        emit              = 1'b1;
        result.error_code = dwev_pkg::ERR_UNSUPPORTED;
      end else if (is_leb && item.data_byte[7]) begin
        held_nxt = enc_c;
        if (cnt_inc >= 5'(dwev_pkg::MAX_LEB_BYTES)) begin
          emit              = 1'b1;
          result.error_code = dwev_pkg::ERR_LEB_LONG;
          acc_nxt           = 64'd0;
          count_nxt         = 4'd0;
          active_nxt        = 1'b0;
        end else begin
          acc_nxt    = leb_acc;
          count_nxt  = cnt_inc[3:0];
          active_nxt = 1'b1;
        end
      end else if (!is_leb && cnt_inc < 5'(size)) begin
        held_nxt   = enc_c;
        acc_nxt    = fix_acc;
        count_nxt  = cnt_inc[3:0];
        active_nxt = 1'b1;
      end else begin
        done = 1'b1;
      end
      if (done) begin
        emit                  = 1'b1;
        held_nxt              = enc_c;
        result.value          = final_val;
        result.needs_indirect = enc_c[7] && (final_val != 64'd0);
        acc_nxt               = 64'd0;
        count_nxt             = 4'd0;
        active_nxt            = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 64'd0;
      count_r  <= 4'd0;
      active_r <= 1'b0;
      held_r   <= 8'd0;
    end else begin
      acc_r    <= acc_nxt;
      count_r  <= count_nxt;
      active_r <= active_nxt;
      held_r   <= held_nxt;
    end
  end

  `DWEV_ASSERT_NOW(a_count_bound, active_r, count_r < 4'(dwev_pkg::MAX_LEB_BYTES))
  `DWEV_ASSERT_NOW(a_idle_clean, !active_r, count_r == 4'd0 && acc_r == 64'd0)
  `DWEV_ASSERT_NEXT(a_emit_idles, en && emit, !active_r)

endmodule

`default_nettype wire
